// File: src/kds_pkg.sv
package kds_pkg;

    // digit storage bounds and the digits that the display word carries
    localparam int DEFAULT_NUM_DIGITS = 6;
    localparam int MAX_DIGITS         = 8;
    localparam int SHOWN_DIGITS       = 6;
    localparam int SEG_W              = 8;
    localparam int DISPLAY_W          = SHOWN_DIGITS * SEG_W;

    // keypad geometry
    localparam int KEY_ROWS  = 4;
    localparam int KEY_COLS  = 5;
    localparam int ROW_IDX_W = 2;
    localparam int KEY_CODE_W = 5;

    // register reset values and read word marks
    localparam logic [7:0] BLANK_TIMEOUT_RESET = 8'h80;
    localparam logic [7:0] KEY_READ_MARK       = 8'hE0;
    localparam logic [7:0] KEY_READ_MARK_SHIFT = 8'hC0;
    localparam logic [7:0] LATCH_NO_KEY        = 8'h40;
    localparam logic [7:0] LATCH_TAPE          = 8'h80;
    localparam logic [5:0] DIGIT_EN_MASK       = 6'h3F;

    typedef enum logic [2:0] {
        ACT_SCAN_TICK  = 3'd0,
        ACT_DIGIT_WR   = 3'd1,
        ACT_SEGMENT_WR = 3'd2,
        ACT_KEY_READ   = 3'd3,
        ACT_LATCH_READ = 3'd4
    } action_t;

    typedef logic [KEY_ROWS-1:0][KEY_COLS-1:0] key_rows_t;

    // strobes from the decoder to the display and keypad units
    typedef struct packed {
        logic scan_tick;
        logic key_read;
    } kds_ctrl_t;

    // latch bits 7..0 take data bits 4,2,1,6,7,5,3,0
    function automatic logic [SEG_W-1:0] permute_segments(input logic [SEG_W-1:0] d);
        return {d[4], d[2], d[1], d[6], d[7], d[5], d[3], d[0]};
    endfunction

    // row number plus a column code from the lowest set column among bits 1..4
    function automatic logic [KEY_CODE_W-1:0] encode_key(
        input logic [KEY_COLS-1:0]  cols,
        input logic [ROW_IDX_W-1:0] row
    );
        logic [2:0] col_code;
        col_code = 3'd0;
        priority if (cols[1])
            col_code = 3'd1;
        else if (cols[2])
            col_code = 3'd2;
        else if (cols[3])
            col_code = 3'd3;
        else if (cols[4])
            col_code = 3'd4;
        else
            col_code = 3'd0;
        return {col_code, row};
    endfunction

endpackage

// File: src/kds_if.sv
// command word channel
interface kds_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] write_data;
    logic [4:0] key_row0;
    logic [4:0] key_row1;
    logic [4:0] key_row2;
    logic [4:0] key_row3;
    logic       shift_pressed;
    logic       tape_in;

    modport source (
        output valid, action, write_data, key_row0, key_row1, key_row2, key_row3,
               shift_pressed, tape_in,
        input  ready
    );
    modport sink (
        input  valid, action, write_data, key_row0, key_row1, key_row2, key_row3,
               shift_pressed, tape_in,
        output ready
    );
endinterface

// result word channel
interface kds_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic        nmi_request;
    logic        speaker_level;
    logic        key_held;
    logic [47:0] display_segments;

    modport source (
        output valid, read_data, nmi_request, speaker_level, key_held, display_segments,
        input  ready
    );
    modport sink (
        input  valid, read_data, nmi_request, speaker_level, key_held, display_segments,
        output ready
    );
endinterface

// File: src/kds_display.sv
module kds_display #(
    parameter int NUM_DIGITS = kds_pkg::DEFAULT_NUM_DIGITS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  kds_pkg::kds_ctrl_t       ctrl,
    input  logic [7:0]               segment_latch,
    input  logic [5:0]               digit_enables,
    input  logic [7:0]               blank_timeout,
    output logic [kds_pkg::DISPLAY_W-1:0] display_segments
);
    import kds_pkg::*;

    localparam int STORE_DIGITS = (NUM_DIGITS < MAX_DIGITS) ? NUM_DIGITS : MAX_DIGITS;

    logic [STORE_DIGITS-1:0][7:0]       age_reg;
    logic [STORE_DIGITS-1:0][7:0]       age_next;
    logic [STORE_DIGITS-1:0][SEG_W-1:0] shown_reg;
    logic [STORE_DIGITS-1:0][SEG_W-1:0] shown_next;

    for (genvar d = 0; d < STORE_DIGITS; d++) begin : g_digit
        logic enabled;

        // only the first six digits have an enable bit
        if (d < SHOWN_DIGITS) begin : g_en
            assign enabled = digit_enables[d];
        end else begin : g_no_en
            assign enabled = 1'b0;
        end

        // refresh, blank on timeout, or age
        always_comb
        begin
            age_next[d]   = age_reg[d];
            shown_next[d] = shown_reg[d];
            if (ctrl.scan_tick) begin
                if (enabled) begin
                    age_next[d]   = 8'd1;
                    shown_next[d] = segment_latch;
                end else if (age_reg[d] == blank_timeout) begin
                    age_next[d]   = 8'd0;
                    shown_next[d] = '0;
                end else if (age_reg[d] != 8'd0) begin
                    age_next[d]   = age_reg[d] + 8'd1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                age_reg[d]   <= '0;
                shown_reg[d] <= '0;
            end else begin
                age_reg[d]   <= age_next[d];
                shown_reg[d] <= shown_next[d];
            end
        end
    end

    // display word, digits beyond the stored count read blank
    for (genvar s = 0; s < SHOWN_DIGITS; s++) begin : g_show
        if (s < STORE_DIGITS) begin : g_live
            assign display_segments[s*SEG_W +: SEG_W] = shown_reg[s];
        end else begin : g_blank
            assign display_segments[s*SEG_W +: SEG_W] = '0;
        end
    end

endmodule

// File: src/kds_keypad.sv
module kds_keypad (
    input  logic                              clk,
    input  logic                              rst_n,
    input  kds_pkg::kds_ctrl_t                ctrl,
    input  kds_pkg::key_rows_t                rows,
    output logic [kds_pkg::KEY_CODE_W-1:0]    key_code,
    output logic                              key_flag,
    output logic                              nmi_flag
);
    import kds_pkg::*;

    logic [KEY_CODE_W-1:0] key_code_reg;
    logic [KEY_CODE_W-1:0] key_code_next;
    logic [ROW_IDX_W-1:0]  scan_row_reg;
    logic [ROW_IDX_W-1:0]  scan_row_next;
    logic                  key_flag_reg;
    logic                  key_flag_next;
    logic                  nmi_reg;
    logic                  nmi_next;

    logic [KEY_COLS-1:0]   cur_cols;
    logic [KEY_COLS-1:0]   nxt_cols;
    logic [ROW_IDX_W-1:0]  row_inc;
    logic                  held;

    assign cur_cols = rows[scan_row_reg];
    assign row_inc  = scan_row_reg + ROW_IDX_W'(1);
    assign nxt_cols = rows[row_inc];
    // previous key still down on the current row holds the scan
    assign held     = (cur_cols != '0) && (encode_key(cur_cols, scan_row_reg) == key_code_reg);

    // scan step and interrupt clear
    always_comb
    begin
        key_code_next = key_code_reg;
        scan_row_next = scan_row_reg;
        key_flag_next = key_flag_reg;
        nmi_next      = nmi_reg;
        if (ctrl.key_read) begin
            nmi_next = 1'b0;
        end
        if (ctrl.scan_tick && !held) begin
            scan_row_next = row_inc;
            if (nxt_cols != '0) begin
                key_code_next = encode_key(nxt_cols, row_inc);
                nmi_next      = 1'b1;
                key_flag_next = 1'b1;
            end else begin
                key_flag_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            key_code_reg <= '0;
            scan_row_reg <= '0;
            key_flag_reg <= 1'b0;
            nmi_reg      <= 1'b0;
        end else begin
            key_code_reg <= key_code_next;
            scan_row_reg <= scan_row_next;
            key_flag_reg <= key_flag_next;
            nmi_reg      <= nmi_next;
        end
    end

    assign key_code = key_code_reg;
    assign key_flag = key_flag_reg;
    assign nmi_flag = nmi_reg;

endmodule

// File: src/keypad_scan_and_led_digit_latch.sv
// Keypad scanner and multiplexed LED digit latch. Each command word is one bus action
// (scan tick, digit write, segment write, key read, latch read) and yields exactly one
// result word. A command is taken every cycle that the result slot is empty or being
// emptied; its result is registered and shows in the cycle after acceptance. The result
// carries read_data for that command plus the interrupt, speaker, key-held and display
// state as left by it. The user writes blank_timeout via cfg_wen/cfg_wdata only while no
// command is in flight (the block does not enforce this); it resets to 128.
module keypad_scan_and_led_digit_latch #(
    parameter int NUM_DIGITS = kds_pkg::DEFAULT_NUM_DIGITS
) (
    input  logic               clk,
    input  logic               rst_n,
    kds_cmd_if.sink            cmd,
    kds_result_if.source       result,
    input  logic               cfg_wen,
    input  logic [7:0]         cfg_wdata
);
    import kds_pkg::*;

    logic                  accept;
    kds_ctrl_t             ctrl;
    key_rows_t             rows;
    logic [KEY_CODE_W-1:0] key_code;
    logic                  key_flag;
    logic                  nmi_flag;
    logic [DISPLAY_W-1:0]  display_word;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] read_data_reg;
    logic [7:0] read_data_next;
    logic [7:0] segment_latch_reg;
    logic [7:0] segment_latch_next;
    logic [5:0] digit_enables_reg;
    logic [5:0] digit_enables_next;
    logic       speaker_reg;
    logic       speaker_next;
    logic [7:0] blank_timeout_reg;

    // a new word enters when the result slot is empty or being emptied
    assign cmd.ready = !out_valid_reg || result.ready;
    assign accept    = cmd.valid && cmd.ready;
    assign rows      = {cmd.key_row3, cmd.key_row2, cmd.key_row1, cmd.key_row0};

    // action decode
    always_comb
    begin
        ctrl               = '0;
        read_data_next     = '0;
        segment_latch_next = segment_latch_reg;
        digit_enables_next = digit_enables_reg;
        speaker_next       = speaker_reg;
        if (accept) begin
            unique case (action_t'(cmd.action))
                ACT_SCAN_TICK: begin
                    ctrl.scan_tick = 1'b1;
                end
                ACT_DIGIT_WR: begin
                    speaker_next       = cmd.write_data[7];
                    digit_enables_next = cmd.write_data[5:0] & DIGIT_EN_MASK;
                end
                ACT_SEGMENT_WR: begin
                    segment_latch_next = permute_segments(cmd.write_data);
                end
                ACT_KEY_READ: begin
                    ctrl.key_read  = 1'b1;
                    read_data_next = {3'b000, key_code}
                                   | (cmd.shift_pressed ? KEY_READ_MARK_SHIFT : KEY_READ_MARK);
                end
                ACT_LATCH_READ: begin
                    read_data_next = (key_flag ? 8'h00 : LATCH_NO_KEY)
                                   | (cmd.tape_in ? LATCH_TAPE : 8'h00);
                end
                default: begin
                end
            endcase
        end
    end

    // result slot
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg     <= 1'b0;
            segment_latch_reg <= '0;
            digit_enables_reg <= '0;
            speaker_reg       <= 1'b0;
            blank_timeout_reg <= BLANK_TIMEOUT_RESET;
        end else begin
            out_valid_reg     <= out_valid_next;
            segment_latch_reg <= segment_latch_next;
            digit_enables_reg <= digit_enables_next;
            speaker_reg       <= speaker_next;
            if (cfg_wen)
                blank_timeout_reg <= cfg_wdata;
        end
    end

    // read word is payload only
    always_ff @(posedge clk)
    begin
        if (accept)
            read_data_reg <= read_data_next;
    end

    kds_display #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_display (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctrl             (ctrl),
        .segment_latch    (segment_latch_reg),
        .digit_enables    (digit_enables_reg),
        .blank_timeout    (blank_timeout_reg),
        .display_segments (display_word)
    );

    kds_keypad u_keypad (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .rows     (rows),
        .key_code (key_code),
        .key_flag (key_flag),
        .nmi_flag (nmi_flag)
    );

    // state changes only when a word is taken, so it stays with the waiting result
    assign result.valid            = out_valid_reg;
    assign result.read_data        = read_data_reg;
    assign result.nmi_request      = nmi_flag;
    assign result.speaker_level    = speaker_reg;
    assign result.key_held         = key_flag;
    assign result.display_segments = display_word;

endmodule

// File: bench/kds_result_check.sv
// watches the command and result channels, keeps its own copy of the keypad and
// display state, and compares each result word with the oldest prediction
module kds_result_check
    import kds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    kds_cmd_if          cmd,
    kds_result_if       result,
    input  logic        cfg_wen,
    input  logic [7:0]  cfg_wdata,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        logic [7:0]           read_data;
        logic                 nmi;
        logic                 spk;
        logic                 held;
        logic [DISPLAY_W-1:0] segs;
    } result_word_t;

    // data bit that feeds each latch bit, latch bit 0 first
    localparam int SEG_SRC [SEG_W] = '{0, 3, 5, 7, 6, 1, 2, 4};

    // predicted block state
    logic [7:0]            blank_after;
    logic [SEG_W-1:0]      seg_latch;
    logic [5:0]            enables;
    logic [KEY_CODE_W-1:0] code;
    logic [ROW_IDX_W-1:0]  row;
    logic                  held;
    logic                  nmi;
    logic                  spk;
    logic [7:0]            age   [SHOWN_DIGITS];
    logic [SEG_W-1:0]      shown [SHOWN_DIGITS];

    result_word_t expected_q [$];
    int           mismatches;

    // lowest pressed column among bits 1..4 gives the column part
    function automatic logic [KEY_CODE_W-1:0] key_code_of(logic [KEY_COLS-1:0] cols,
                                                          logic [ROW_IDX_W-1:0] r);
        logic [2:0] col;
        col = 3'd0;
        for (int c = KEY_COLS - 1; c >= 1; c--)
            if (cols[c])
                col = 3'(c);
        return {col, r};
    endfunction

    function automatic logic [SEG_W-1:0] scramble(logic [SEG_W-1:0] d);
        logic [SEG_W-1:0] r;
        for (int b = 0; b < SEG_W; b++)
            r[b] = d[SEG_SRC[b]];
        return r;
    endfunction

    // digit refresh and blanking, then one keypad scan step
    task automatic scan_tick(input key_rows_t rows);
        for (int i = 0; i < SHOWN_DIGITS; i++)
        begin
            if (enables[i])
            begin
                age[i]   = 8'd1;
                shown[i] = seg_latch;
            end
            else if (age[i] == blank_after)
            begin
                shown[i] = '0;
                age[i]   = 8'd0;
            end
            else if (age[i] != 8'd0)
            begin
                age[i] = age[i] + 8'd1;
            end
        end
        // key still held on the current row: scan stays put
        if (rows[row] != '0 && key_code_of(rows[row], row) == code)
            return;
        row = row + ROW_IDX_W'(1);
        if (rows[row] != '0)
        begin
            code = key_code_of(rows[row], row);
            nmi  = 1'b1;
            held = 1'b1;
        end
        else
        begin
            held = 1'b0;
        end
    endtask

    task automatic predict_word();
        key_rows_t    rows;
        logic [7:0]   rd;
        result_word_t w;
        rows = {cmd.key_row3, cmd.key_row2, cmd.key_row1, cmd.key_row0};
        rd   = 8'h00;
        case (cmd.action)
            ACT_SCAN_TICK:
                scan_tick(rows);
            ACT_DIGIT_WR:
            begin
                spk     = cmd.write_data[7];
                enables = cmd.write_data[5:0] & DIGIT_EN_MASK;
            end
            ACT_SEGMENT_WR:
                seg_latch = scramble(cmd.write_data);
            ACT_KEY_READ:
            begin
                nmi = 1'b0;
                rd  = {3'b000, code} | (cmd.shift_pressed ? KEY_READ_MARK_SHIFT : KEY_READ_MARK);
            end
            ACT_LATCH_READ:
                rd = (held ? 8'h00 : LATCH_NO_KEY) | (cmd.tape_in ? LATCH_TAPE : 8'h00);
            default:
                ;
        endcase
        w.read_data = rd;
        w.nmi       = nmi;
        w.spk       = spk;
        w.held      = held;
        for (int i = 0; i < SHOWN_DIGITS; i++)
            w.segs[i*SEG_W +: SEG_W] = shown[i];
        expected_q.push_back(w);
    endtask

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
            mismatches++;
        end
    endtask

    task automatic compare_word();
        result_word_t want;
        result_word_t got;
        got = {result.read_data, result.nmi_request, result.speaker_level,
               result.key_held, result.display_segments};
        if (expected_q.size() == 0)
        begin
            $display("%0t: result word with nothing predicted, expected none, actual %h",
                     $time, got);
            mismatches++;
        end
        else
        begin
            want = expected_q.pop_front();
            check_field("read_data", want.read_data, got.read_data);
            check_field("nmi_request", want.nmi, got.nmi);
            check_field("speaker_level", want.spk, got.spk);
            check_field("key_held", want.held, got.held);
            check_field("display_segments", want.segs, got.segs);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blank_after = BLANK_TIMEOUT_RESET;
            seg_latch   = '0;
            enables     = '0;
            code        = '0;
            row         = '0;
            held        = 1'b0;
            nmi         = 1'b0;
            spk         = 1'b0;
            for (int i = 0; i < SHOWN_DIGITS; i++)
            begin
                age[i]   = 8'd0;
                shown[i] = '0;
            end
            expected_q.delete();
            mismatches = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_wen)
                blank_after = cfg_wdata;
            // retire the old word before predicting a new one
            if (result.valid && result.ready)
                compare_word();
            if (cmd.valid && cmd.ready)
                predict_word();
            errors  <= mismatches;
            pending <= expected_q.size();
        end
    end

endmodule

// File: bench/tb.sv
module tb;
    import kds_pkg::*;

    // action codes the block ignores
    localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
    localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

    logic       clk;
    logic       rst_n;
    logic       cfg_wen;
    logic [7:0] cfg_wdata;
    int         errors;
    int         pending;

    // keys currently pressed, one five-bit column mask per row
    logic [KEY_COLS-1:0] pad [KEY_ROWS];
    int                  burst_left;

    kds_cmd_if    cmd ();
    kds_result_if result ();

    keypad_scan_and_led_digit_latch uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .result    (result),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    kds_result_check check_unit (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .result    (result),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        #8000000;
        $display("== FAIL ==");
        $finish;
    end

    // result receiver: a long hold-off early on, then random stall patterns
    initial
    begin
        int mode;
        int span;
        result.ready <= 1'b0;
        wait (rst_n === 1'b1);
        repeat (30)
        begin
            @(posedge clk);
            result.ready <= 1'b1;
        end
        repeat (60)
        begin
            @(posedge clk);
            result.ready <= 1'b0;
        end
        forever
        begin
            mode = $urandom_range(0, 9);
            span = (mode == 9) ? $urandom_range(30, 80) : $urandom_range(10, 150);
            repeat (span)
            begin
                @(posedge clk);
                if (mode < 4)
                    result.ready <= 1'b1;
                else if (mode < 7)
                    result.ready <= 1'($urandom_range(0, 1));
                else if (mode < 9)
                    result.ready <= ($urandom_range(0, 3) == 0);
                else
                    result.ready <= 1'b0;
            end
        end
    end

    // offer one word, idling between bursts, and wait until it is taken
    task automatic send_word(input logic [2:0] act, input logic [7:0] data,
                             input logic shift, input logic tape);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                cmd.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        cmd.valid         <= 1'b1;
        cmd.action        <= act;
        cmd.write_data    <= data;
        cmd.key_row0      <= pad[0];
        cmd.key_row1      <= pad[1];
        cmd.key_row2      <= pad[2];
        cmd.key_row3      <= pad[3];
        cmd.shift_pressed <= shift;
        cmd.tape_in       <= tape;
        do
            @(posedge clk);
        while (!cmd.ready);
    endtask

    task automatic drain_results();
        cmd.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic set_blank_timeout(input logic [7:0] value);
        drain_results();
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen   <= 1'b0;
    endtask

    // one random action; the keypad changes now and then and keys stay down a while
    task automatic random_word(input int dig_weight, input logic [5:0] keep_mask);
        int          k;
        int          r;
        int          c;
        int unsigned roll;
        logic [2:0]  act;
        logic [7:0]  data;
        if ($urandom_range(0, 9) == 0)
        begin
            k = $urandom_range(0, 19);
            foreach (pad[i])
                pad[i] = '0;
            if (k >= 8 && k < 19)
            begin
                r = $urandom_range(0, KEY_ROWS - 1);
                c = $urandom_range(0, KEY_COLS - 1);
                pad[r][c] = 1'b1;
                if (k >= 16)
                begin
                    r = $urandom_range(0, KEY_ROWS - 1);
                    c = $urandom_range(0, KEY_COLS - 1);
                    pad[r][c] = 1'b1;
                end
            end
            else if (k == 19)
            begin
                foreach (pad[i])
                    pad[i] = KEY_COLS'($urandom);
            end
        end
        data = 8'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < dig_weight)
        begin
            act = ACT_DIGIT_WR;
            if ($urandom_range(0, 1) == 1)
                data[5:0] = data[5:0] & 6'($urandom);
            data[5:0] = data[5:0] & keep_mask;
        end
        else if (roll < dig_weight + 12)
            act = ACT_SEGMENT_WR;
        else if (roll < dig_weight + 22)
            act = ACT_KEY_READ;
        else if (roll < dig_weight + 30)
            act = ACT_LATCH_READ;
        else if (roll < dig_weight + 32)
            act = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
        else
            act = ACT_SCAN_TICK;
        send_word(act, data, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic run_phase(input logic [7:0] timeout_value, input int count,
                             input int dig_weight, input logic [5:0] keep_mask);
        set_blank_timeout(timeout_value);
        repeat (count) random_word(dig_weight, keep_mask);
    endtask

    initial
    begin
        cmd.valid         <= 1'b0;
        cmd.action        <= ACT_SCAN_TICK;
        cmd.write_data    <= '0;
        cmd.key_row0      <= '0;
        cmd.key_row1      <= '0;
        cmd.key_row2      <= '0;
        cmd.key_row3      <= '0;
        cmd.shift_pressed <= 1'b0;
        cmd.tape_in       <= 1'b0;
        cfg_wen           <= 1'b0;
        cfg_wdata         <= '0;
        rst_n             <= 1'b0;
        foreach (pad[i])
            pad[i] = '0;
        burst_left = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reads straight out of reset
        send_word(ACT_LATCH_READ, 8'h00, 1'b0, 1'b1);
        send_word(ACT_KEY_READ, 8'h00, 1'b0, 1'b0);
        send_word(ACT_KEY_READ, 8'h00, 1'b1, 1'b0);
        // segment patterns into every digit, speaker on
        send_word(ACT_SEGMENT_WR, 8'hFF, 1'b0, 1'b0);
        send_word(ACT_DIGIT_WR, 8'hBF, 1'b0, 1'b0);
        send_word(ACT_SCAN_TICK, 8'h00, 1'b0, 1'b0);
        send_word(ACT_SEGMENT_WR, 8'hA5, 1'b0, 1'b0);
        send_word(ACT_SCAN_TICK, 8'h00, 1'b0, 1'b0);
        send_word(ACT_SEGMENT_WR, 8'h5A, 1'b0, 1'b0);
        // all digits off, speaker off; ageing starts
        send_word(ACT_DIGIT_WR, 8'h00, 1'b0, 1'b0);
        send_word(ACT_SCAN_TICK, 8'h00, 1'b0, 1'b0);
        // column 0 only on row 0, highest column on row 3
        pad[0] = 5'b00001;
        pad[3] = 5'b10000;
        send_word(ACT_SCAN_TICK, 8'h00, 1'b0, 1'b0);
        send_word(ACT_SCAN_TICK, 8'h00, 1'b0, 1'b0);
        send_word(ACT_LATCH_READ, 8'h00, 1'b0, 1'b0);
        send_word(ACT_KEY_READ, 8'h00, 1'b1, 1'b0);
        // release row 3: scan moves on to the bare column-0 key and holds there
        pad[3] = 5'b00000;
        send_word(ACT_SCAN_TICK, 8'h00, 1'b0, 1'b0);
        send_word(ACT_SCAN_TICK, 8'h00, 1'b0, 1'b0);
        // different key on the same row no longer matches the held code
        pad[0] = 5'b11110;
        send_word(ACT_SCAN_TICK, 8'h00, 1'b0, 1'b0);
        // ignored actions with everything pressed
        foreach (pad[i])
            pad[i] = 5'h1F;
        send_word(ACT_UNUSED_LO, 8'hFF, 1'b1, 1'b1);
        send_word(ACT_UNUSED_HI, 8'hFF, 1'b1, 1'b1);
        send_word(ACT_SCAN_TICK, 8'h00, 1'b1, 1'b1);
        send_word(ACT_DIGIT_WR, 8'h7F, 1'b0, 1'b0);
        send_word(ACT_KEY_READ, 8'h00, 1'b0, 1'b1);
        foreach (pad[i])
            pad[i] = '0;

        // random traffic over several blanking timeouts
        repeat (200) random_word(8, 6'h3F);
        run_phase(8'd1, 300, 8, 6'h3F);
        run_phase(8'd255, 500, 2, 6'h07);
        run_phase(8'd0, 450, 2, 6'h38);
        run_phase(8'($urandom_range(2, 254)), 250, 5, 6'h3F);
        run_phase(8'd3, 200, 15, 6'h3F);

        drain_results();
        repeat (4) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
